@@ hdl/spc_pkg.sv @@
// Shared types, constants and helper functions for the shutter position controller.
// No dependencies; every other file in hdl/ imports this package.
package spc_pkg;

  // Level scale: 0 is fully open, LEVEL_TOP is fully closed.
  localparam int LEVEL_TOP        = 100;
  localparam int TICKS_PER_SECOND = 1000;
  localparam int LEVEL_TICKS      = TICKS_PER_SECOND / LEVEL_TOP;

  // Field widths.
  localparam int CMD_W   = 3;
  localparam int VALUE_W = 8;
  localparam int DIR_W   = 2;
  localparam int KIND_W  = 3;
  localparam int LEVEL_W = 7;
  localparam int TIME_W  = 8;
  localparam int DELAY_W = 10;
  localparam int WAIT_W  = 12;
  localparam int PROD_W  = TIME_W + $clog2(LEVEL_TICKS + 1);

  // Configuration port.
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 10;

  // Reset values.
  localparam int SHUT_SNAP_RESET     = 90;
  localparam int OPEN_SNAP_RESET     = 10;
  localparam int START_DELAY_RESET   = 50;
  localparam int DEFAULT_TRAVEL_TIME = 30;
  localparam int RESET_STEP_PERIOD   = 100;
  localparam int PERIOD_MAX          = 4095;

  // Start directions.
  localparam logic [DIR_W-1:0] DIR_CLOSE  = 2'd0;
  localparam logic [DIR_W-1:0] DIR_OPEN   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_TOGGLE = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_SET_POS = 3'd0,
    CMD_MOVE_TO = 3'd1,
    CMD_START   = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_STATUS  = 3'd4,
    CMD_TICK    = 3'd5
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    EV_NONE         = 3'd0,
    EV_STARTED      = 3'd1,
    EV_STOPPED_OPEN = 3'd2,
    EV_STOPPED_POS  = 3'd3,
    EV_STATUS       = 3'd4
  } evt_t;

  // Motor sub-state sequence.
  typedef enum logic [2:0] {
    STEP_NONE        = 3'd0,
    STEP_START       = 3'd1,
    STEP_NOTIFY_RUN  = 3'd2,
    STEP_RUNNING     = 3'd3,
    STEP_STOP        = 3'd4,
    STEP_NOTIFY_STOP = 3'd5
  } step_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CLOSE_TIME  = 3'd0,
    CFG_OPEN_TIME   = 3'd1,
    CFG_START_DELAY = 3'd2,
    CFG_SHUT_SNAP   = 3'd3,
    CFG_OPEN_SNAP   = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [TIME_W-1:0]  close_time;
    logic [TIME_W-1:0]  open_time;
    logic [DELAY_W-1:0] start_delay;
    logic [LEVEL_W-1:0] shut_snap;
    logic [LEVEL_W-1:0] open_snap;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [VALUE_W-1:0] value;
    logic [DIR_W-1:0]   direction;
  } item_t;

  typedef struct packed {
    evt_t               event_kind;
    logic               event_direction;
    logic [LEVEL_W-1:0] report_position;
    logic               motor_on;
    logic               motor_to_open;
    logic               save_position;
  } result_t;

  // Saturate a level to the top of the scale.
  function automatic logic [LEVEL_W-1:0] clamp_level(input logic [VALUE_W-1:0] v);
    if (v > VALUE_W'(LEVEL_TOP)) begin
      return LEVEL_W'(LEVEL_TOP);
    end
    return v[LEVEL_W-1:0];
  endfunction

  // Ticks per level step for a given full travel time, saturated.
  function automatic logic [WAIT_W-1:0] travel_period(input logic [TIME_W-1:0] secs);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(secs) * PROD_W'(LEVEL_TICKS);
    if (prod > PROD_W'(PERIOD_MAX)) begin
      return WAIT_W'(PERIOD_MAX);
    end
    return WAIT_W'(prod);
  endfunction

endpackage

@@ hdl/spc_if.sv @@
// Stream interfaces for the command channel and the event channel.
// Depends on spc_pkg for field widths.
interface spc_item_if import spc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [VALUE_W-1:0] value;
  logic [DIR_W-1:0]   direction;

  modport source (output valid, cmd, value, direction, input ready);
  modport sink   (input valid, cmd, value, direction, output ready);
endinterface

interface spc_result_if import spc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  event_kind;
  logic               event_direction;
  logic [LEVEL_W-1:0] report_position;
  logic               motor_on;
  logic               motor_to_open;
  logic               save_position;

  modport source (output valid, event_kind, event_direction, report_position, motor_on,
                  motor_to_open, save_position, input ready);
  modport sink   (input valid, event_kind, event_direction, report_position, motor_on,
                  motor_to_open, save_position, output ready);
endinterface

@@ hdl/spc_cfg.sv @@
// Configuration register file: travel times, start delay and snap thresholds.
// Depends on spc_pkg.
module spc_cfg import spc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   write,
  input  logic [CFG_INDEX_W-1:0] index,
  input  logic [CFG_DATA_W-1:0]  data,
  output cfg_t                   cfg
);

  cfg_t regs;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.close_time  <= TIME_W'(DEFAULT_TRAVEL_TIME);
      regs.open_time   <= TIME_W'(DEFAULT_TRAVEL_TIME);
      regs.start_delay <= DELAY_W'(START_DELAY_RESET);
      regs.shut_snap   <= LEVEL_W'(SHUT_SNAP_RESET);
      regs.open_snap   <= LEVEL_W'(OPEN_SNAP_RESET);
    end else if (write) begin
      case (cfg_index_t'(index))
        CFG_CLOSE_TIME:  regs.close_time  <= data[TIME_W-1:0];
        CFG_OPEN_TIME:   regs.open_time   <= data[TIME_W-1:0];
        CFG_START_DELAY: regs.start_delay <= data[DELAY_W-1:0];
        CFG_SHUT_SNAP:   regs.shut_snap   <= data[LEVEL_W-1:0];
        CFG_OPEN_SNAP:   regs.open_snap   <= data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

endmodule

@@ hdl/spc_ctrl.sv @@
// Shutter control state and its one-item update: position estimate, target,
// motor step sequence and relay drive. Depends on spc_pkg.
module spc_ctrl import spc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    fire,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t res
);

  // State registers
  logic               running;
  step_t              step;
  logic [LEVEL_W-1:0] cur;
  logic [LEVEL_W-1:0] tgt;
  logic               toggle;
  logic               to_open;
  logic               drive_on;
  logic [WAIT_W-1:0]  wait_cnt;
  logic [WAIT_W-1:0]  period;

  logic               running_next;
  step_t              step_next;
  logic [LEVEL_W-1:0] cur_next;
  logic [LEVEL_W-1:0] tgt_next;
  logic               toggle_next;
  logic               to_open_next;
  logic               drive_on_next;
  logic [WAIT_W-1:0]  wait_cnt_next;
  logic [WAIT_W-1:0]  period_next;

  // Working signals of the update
  logic               close_dir;
  logic               do_move;
  logic [LEVEL_W-1:0] move_tgt;
  logic               do_stop;
  logic               do_seq;
  logic               run_level;
  logic               stop_seq;
  logic               launch;
  logic               launch_open;
  logic [LEVEL_W-1:0] lvl;
  logic               reach;
  logic [WAIT_W-1:0]  delay;

  assign delay = WAIT_W'(cfg.start_delay);

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      step     <= STEP_NONE;
      cur      <= '0;
      tgt      <= '0;
      toggle   <= 1'b0;
      to_open  <= 1'b0;
      drive_on <= 1'b0;
      wait_cnt <= '0;
      period   <= WAIT_W'(RESET_STEP_PERIOD);
    end else if (fire) begin
      running  <= running_next;
      step     <= step_next;
      cur      <= cur_next;
      tgt      <= tgt_next;
      toggle   <= toggle_next;
      to_open  <= to_open_next;
      drive_on <= drive_on_next;
      wait_cnt <= wait_cnt_next;
      period   <= period_next;
    end
  end

  always_comb begin
    running_next  = running;
    step_next     = step;
    cur_next      = cur;
    tgt_next      = tgt;
    toggle_next   = toggle;
    to_open_next  = to_open;
    drive_on_next = drive_on;
    wait_cnt_next = wait_cnt;
    period_next   = period;

    res.event_kind      = EV_NONE;
    res.event_direction = 1'b0;
    res.report_position = '0;
    res.save_position   = 1'b0;

    close_dir = 1'b0;
    do_move   = 1'b0;
    move_tgt  = '0;
    do_stop   = 1'b0;
    do_seq    = 1'b0;
    run_level = 1'b0;
    stop_seq  = 1'b0;
    launch    = 1'b0;
    lvl       = cur;
    reach     = 1'b0;

    // Command decode
    case (cmd_t'(item.cmd))
      CMD_SET_POS: cur_next = clamp_level(item.value);
      CMD_MOVE_TO: begin
        do_move  = 1'b1;
        move_tgt = clamp_level(item.value);
      end
      CMD_START: begin
        if (item.direction == DIR_TOGGLE) begin
          close_dir = !toggle;
        end else begin
          close_dir = (item.direction == DIR_CLOSE);
        end
        do_move = 1'b1;
        // Snap the position estimate back to the snap threshold when starting past it
        if (close_dir) begin
          if (cur > cfg.shut_snap) begin
            cur_next = clamp_level(VALUE_W'(cfg.shut_snap));
          end
          toggle_next = 1'b1;
          move_tgt    = LEVEL_W'(LEVEL_TOP);
        end else begin
          if (cur < cfg.open_snap) begin
            cur_next = clamp_level(VALUE_W'(cfg.open_snap));
          end
          toggle_next = 1'b0;
          move_tgt    = '0;
        end
      end
      CMD_STOP: do_stop = 1'b1;
      CMD_STATUS: begin
        res.event_kind      = EV_STATUS;
        res.report_position = cur;
      end
      CMD_TICK: begin
        if (running) begin
          if (wait_cnt > WAIT_W'(1)) begin
            wait_cnt_next = wait_cnt - WAIT_W'(1);
          end else begin
            wait_cnt_next = '0;
            do_seq        = 1'b1;
          end
        end else begin
          drive_on_next = 1'b0;
        end
      end
      default: ;
    endcase

    // New target; an idle motor starts or settles at once
    if (do_move) begin
      tgt_next = move_tgt;
      if (!running) begin
        if (move_tgt != cur_next) begin
          launch = 1'b1;
        end else begin
          do_stop = 1'b1;
        end
      end
    end

    // Motor sequence step on an expired wait
    if (do_seq) begin
      case (step)
        STEP_START: begin
          drive_on_next = 1'b1;
          wait_cnt_next = delay;
          step_next     = STEP_NOTIFY_RUN;
        end
        STEP_NOTIFY_RUN: begin
          res.event_kind      = EV_STARTED;
          res.event_direction = to_open;
          step_next           = STEP_RUNNING;
          run_level           = 1'b1;
        end
        STEP_RUNNING: run_level = 1'b1;
        STEP_STOP:    stop_seq  = 1'b1;
        STEP_NOTIFY_STOP: begin
          res.event_kind      = (cur != '0) ? EV_STOPPED_POS : EV_STOPPED_OPEN;
          res.report_position = cur;
          running_next        = 1'b0;
          if (cur != tgt) begin
            launch = 1'b1;
          end else begin
            res.save_position = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // One level per poll period toward the target
    if (run_level) begin
      if (cur != tgt) begin
        if (to_open) begin
          lvl         = cur - LEVEL_W'(cur != '0);
          toggle_next = 1'b0;
          reach       = (tgt >= lvl);
        end else begin
          lvl         = (cur < LEVEL_W'(LEVEL_TOP)) ? cur + LEVEL_W'(1) : cur;
          toggle_next = 1'b1;
          reach       = (tgt <= lvl);
        end
        cur_next      = lvl;
        wait_cnt_next = period;
        stop_seq      = reach;
      end else begin
        stop_seq = 1'b1;
      end
    end

    // Explicit stop holds position as the target
    if (do_stop) begin
      running_next = 1'b1;
      tgt_next     = cur_next;
    end

    // Relay off and wait before the stopped notice
    if (do_stop || stop_seq) begin
      drive_on_next = 1'b0;
      step_next     = STEP_NOTIFY_STOP;
      wait_cnt_next = delay;
    end

    // Start toward the target: pick direction and poll period
    launch_open = !(tgt_next > cur_next);
    if (launch) begin
      running_next  = 1'b1;
      to_open_next  = launch_open;
      period_next   = travel_period(launch_open ? cfg.open_time : cfg.close_time);
      step_next     = STEP_START;
      wait_cnt_next = delay;
    end

    res.motor_on      = drive_on_next;
    res.motor_to_open = to_open_next;
  end

endmodule

@@ hdl/shutter_position_controller.sv @@
// Shutter position controller: one command or tick per cycle unless the event
// register stalls, one event per item. An event passes through the stage
// register, then the event register, and a stall can hold it between them.
// Throughput: one item per cycle; the whole state update sits between the stage
// register and the event register, and only a stalled event register holds input.
// Reset (synchronous, active high) clears the pipeline, the control state and
// loads the configuration defaults.
module shutter_position_controller import spc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  spc_item_if.sink               item,
  spc_result_if.source           result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t    cfg;
  item_t   stage;
  logic    stage_valid;
  logic    out_valid;
  result_t out_reg;
  result_t res;
  logic    slot_free;
  logic    advance;

  spc_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .write (cfg_write),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  // Event register is free when empty or its event leaves this cycle
  assign slot_free  = !out_valid || result.ready;
  assign advance    = stage_valid && slot_free;
  assign item.ready = !stage_valid || slot_free;

  // Input stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item.ready) begin
      stage_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      stage.cmd       <= item.cmd;
      stage.value     <= item.value;
      stage.direction <= item.direction;
    end
  end

  spc_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (stage),
    .cfg  (cfg),
    .res  (res)
  );

  // Event register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= res;
    end
  end

  assign result.valid           = out_valid;
  assign result.event_kind      = out_reg.event_kind;
  assign result.event_direction = out_reg.event_direction;
  assign result.report_position = out_reg.report_position;
  assign result.motor_on        = out_reg.motor_on;
  assign result.motor_to_open   = out_reg.motor_to_open;
  assign result.save_position   = out_reg.save_position;

endmodule

@@ hdl/spc_checker.sv @@
// Port-level checks for the shutter position controller, bound to the top level.
// Depends on spc_pkg and on the top level's port names.
module spc_checker import spc_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               result_valid,
  input logic               result_ready,
  input logic [KIND_W-1:0]  event_kind,
  input logic               event_direction,
  input logic [LEVEL_W-1:0] report_position,
  input logic               motor_on,
  input logic               save_position
);

  // A stalled event stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(event_kind)
      && $stable(report_position) && $stable(save_position))
    else $error("stalled event changed");

  // Stopped notices and save requests come with the relay off
  a_stop_off: assert property (@(posedge clk) disable iff (rst)
    result_valid && (event_kind == EV_STOPPED_OPEN || event_kind == EV_STOPPED_POS
      || save_position) |-> !motor_on)
    else $error("motor on at stopped notice");

  // A save request only goes with a stopped notice
  a_save_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid && save_position |->
      (event_kind == EV_STOPPED_OPEN || event_kind == EV_STOPPED_POS))
    else $error("save without stopped notice");

  // Stopped open reports level zero; stopped at position reports a nonzero level
  a_stop_pos: assert property (@(posedge clk) disable iff (rst)
    result_valid && (event_kind == EV_STOPPED_OPEN || event_kind == EV_STOPPED_POS) |->
      ((report_position == '0) == (event_kind == EV_STOPPED_OPEN)))
    else $error("stopped kind disagrees with position");

  // Direction bit and levels stay in range
  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (report_position <= LEVEL_W'(LEVEL_TOP))
      && (!event_direction || event_kind == EV_STARTED))
    else $error("event field out of range");

endmodule

bind shutter_position_controller spc_checker u_spc_checker (
  .clk             (clk),
  .rst             (rst),
  .result_valid    (result.valid),
  .result_ready    (result.ready),
  .event_kind      (result.event_kind),
  .event_direction (result.event_direction),
  .report_position (result.report_position),
  .motor_on        (result.motor_on),
  .save_position   (result.save_position)
);
